// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL; trah_core is the file that includes them.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define TRAH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that one condition implies another on the same edge.
`define TRAH_ASSERT_IMP(lbl, ante, cons, msg) \
  `TRAH_ASSERT(lbl, (ante) |-> (cons), msg)

`else

`define TRAH_ASSERT(lbl, prop, msg)
`define TRAH_ASSERT_IMP(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/trah_pkg.sv =====
package trah_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned DimW    = 13;
  localparam int unsigned SizeW   = 3;
  localparam int unsigned PitchW  = 16;
  localparam int unsigned BufW    = 24;
  localparam int unsigned OffW    = 15;
  localparam int unsigned ProdW   = DimW + PitchW;
  localparam int unsigned NeedW   = ProdW + 1;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = BufW;

  // Reset values of the configuration registers
  localparam logic [DimW-1:0]   TexWidthRst  = 13'd8;
  localparam logic [DimW-1:0]   TexHeightRst = 13'd1;
  localparam logic [SizeW-1:0]  SizeCodeRst  = 3'd0;
  localparam logic [PitchW-1:0] RowPitchRst  = 16'd0;
  localparam logic [BufW-1:0]   BufBytesRst  = 24'hFFFFFF;

  localparam logic [OffW-1:0]   WordBytes    = 15'd4;
  localparam int unsigned       RotAmt       = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TEX_WIDTH  = 3'd0,
    REG_TEX_HEIGHT = 3'd1,
    REG_SIZE_CODE  = 3'd2,
    REG_ROW_PITCH  = 3'd3,
    REG_BUF_BYTES  = 3'd4
  } cfg_reg_e;

  // Settled configuration as seen by the hash datapath
  typedef struct packed {
    logic            restart;   // a register write happened this cycle
    logic            ok;        // configuration passes every check
    logic [OffW-1:0] off_init;  // row bytes minus four
    logic [DimW-1:0] row_init;  // height minus one
  } cfg_t;

  // Row bytes: ((width << size) + 1) / 2, always below 2^15
  function automatic logic [OffW-1:0] line_bytes(input logic [DimW-1:0] width,
                                                 input logic [1:0]      size);
    logic [15:0] shifted;
    logic [16:0] sum;
    begin
      shifted = {3'b000, width} << size;
      sum     = {1'b0, shifted} + 17'd1;
      line_bytes = sum[15:1];
    end
  endfunction

endpackage

// ===== rtl/trah_in_if.sv =====
interface trah_in_if;
  import trah_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] data_word;

  modport source (output valid, output data_word, input ready);
  modport sink   (input valid, input data_word, output ready);
endinterface

// ===== rtl/trah_out_if.sv =====
interface trah_out_if;
  import trah_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] hash_key;
  logic             ok;

  modport source (output valid, output hash_key, output ok, input ready);
  modport sink   (input valid, input hash_key, input ok, output ready);
endinterface

// ===== rtl/trah_cfg.sv =====
module trah_cfg
  import trah_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  logic [DimW-1:0]   width_q, height_q;
  logic [SizeW-1:0]  size_q;
  logic [PitchW-1:0] pitch_q;
  logic [BufW-1:0]   buf_q;

  logic [OffW-1:0]   bpl_d, bpl_q;
  logic [PitchW-1:0] pitch_eff;
  logic              basic_ok_d, basic_ok_q;
  logic [DimW-1:0]   hm1_d, hm1_q;
  logic [ProdW-1:0]  prod_d, prod_q;
  logic [NeedW-1:0]  need;

  // Capture register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= TexWidthRst;
      height_q <= TexHeightRst;
      size_q   <= SizeCodeRst;
      pitch_q  <= RowPitchRst;
      buf_q    <= BufBytesRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_TEX_WIDTH:  width_q  <= cfg_wdata_i[DimW-1:0];
        REG_TEX_HEIGHT: height_q <= cfg_wdata_i[DimW-1:0];
        REG_SIZE_CODE:  size_q   <= cfg_wdata_i[SizeW-1:0];
        REG_ROW_PITCH:  pitch_q  <= cfg_wdata_i[PitchW-1:0];
        REG_BUF_BYTES:  buf_q    <= cfg_wdata_i[BufW-1:0];
        default: ;
      endcase
    end
  end

  // Derive row bytes, the cheap checks and the span product
  always_comb begin
    bpl_d      = line_bytes(width_q, size_q[1:0]);
    pitch_eff  = (pitch_q == '0) ? {1'b0, bpl_d} : pitch_q;
    basic_ok_d = !size_q[2] && (width_q != '0) && (height_q != '0) &&
                 (bpl_d >= WordBytes) && (pitch_eff >= {1'b0, bpl_d});
    hm1_d      = height_q - 13'd1;
    prod_d     = hm1_d * pitch_eff;
  end

  // Register the derived values in the cycle after the configuration registers change
  always_ff @(posedge clk_i) begin
    bpl_q      <= bpl_d;
    basic_ok_q <= basic_ok_d;
    hm1_q      <= hm1_d;
    prod_q     <= prod_d;
  end

  // Finish the bounds check and hand the settings on
  always_comb begin
    need             = {1'b0, prod_q} + {{(NeedW-OffW){1'b0}}, bpl_q};
    cfg_o.restart    = cfg_we_i;
    cfg_o.ok         = basic_ok_q && (need <= {{(NeedW-BufW){1'b0}}, buf_q});
    cfg_o.off_init   = bpl_q - WordBytes;
    cfg_o.row_init   = hm1_q;
  end

endmodule

// ===== rtl/trah_core.sv =====
`include "assert_macros.svh"

module trah_core
  import trah_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             in_valid_i,
  input  logic [WordW-1:0] in_word_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  output logic [WordW-1:0] out_key_o,
  output logic             out_ok_o,
  input  logic             out_ready_i
);

  logic             s1_valid_q;
  logic [WordW-1:0] s1_word_q;

  logic             start_q, start_d;
  logic [WordW-1:0] key_q, key_d;
  logic [OffW-1:0]  off_q, off_d;
  logic [DimW-1:0]  row_q, row_d;

  logic             out_valid_q;
  logic [WordW-1:0] out_key_q, out_key_d;
  logic             out_ok_q, out_ok_d;

  logic [WordW-1:0] key_eff, rot, w, k1, k2;
  logic [OffW-1:0]  off_eff;
  logic [DimW-1:0]  row_eff;
  logic             last_word, emit, s1_fire, in_fire;

  // Hash step for the held word
  always_comb begin
    key_eff   = start_q ? '0 : key_q;
    off_eff   = start_q ? cfg_i.off_init : off_q;
    row_eff   = start_q ? cfg_i.row_init : row_q;
    rot       = {key_eff[WordW-RotAmt-1:0], key_eff[WordW-1:WordW-RotAmt]};
    w         = s1_word_q ^ {{(WordW-OffW){1'b0}}, off_eff};
    k1        = rot + w;
    k2        = k1 + (w ^ {{(WordW-DimW){1'b0}}, row_eff});
    last_word = (off_eff < WordBytes);
    emit      = !cfg_i.ok || (last_word && (row_eff == '0));
  end

  // Handshake: advance the held word unless its result has nowhere to go
  assign s1_fire    = s1_valid_q && (!out_valid_q || out_ready_i || !emit);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_fire    = in_valid_i && in_ready_o;

  // Next texture state and result
  always_comb begin
    start_d   = start_q;
    key_d     = key_q;
    off_d     = off_q;
    row_d     = row_q;
    out_key_d = k2;
    out_ok_d  = 1'b1;
    if (!cfg_i.ok) begin
      out_key_d = '0;
      out_ok_d  = 1'b0;
    end
    if (cfg_i.restart) begin
      start_d = 1'b1;
    end else if (s1_fire) begin
      if (!cfg_i.ok) begin
        start_d = 1'b1;
      end else if (!last_word) begin
        start_d = 1'b0;
        key_d   = k1;
        off_d   = off_eff - WordBytes;
        row_d   = row_eff;
      end else if (row_eff == '0) begin
        start_d = 1'b1;
      end else begin
        start_d = 1'b0;
        key_d   = k2;
        off_d   = cfg_i.off_init;
        row_d   = row_eff - 13'd1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      start_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      start_q <= start_d;
      if (s1_fire && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_word_q <= in_word_i;
    end
    key_q <= key_d;
    off_q <= off_d;
    row_q <= row_d;
    if (s1_fire && emit) begin
      out_key_q <= out_key_d;
      out_ok_q  <= out_ok_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_ok_o    = out_ok_q;

  `TRAH_ASSERT_IMP(a_stall_only_when_held, !in_ready_o, s1_valid_q, "stall without held word")
  `TRAH_ASSERT(a_bad_cfg_zero, (s1_fire && !cfg_i.ok) |=> (out_valid_q && !out_ok_q && out_key_q == '0), "bad config result not zero")
  `TRAH_ASSERT(a_emit_restarts, (s1_fire && emit) |=> start_q, "texture did not restart after result")
  `TRAH_ASSERT_IMP(a_off_align, !start_q, off_q[1:0] == cfg_i.off_init[1:0], "offset lost alignment")

endmodule

// ===== rtl/texture_rotate_add_hash.sv =====
// Each word waits in the stage register; a finished key is registered at the output.
// One word per cycle while the output is not stalled; the hash is a rotate and two 32-bit adds.
// A register write restarts the texture; the checks settle via the config and derived registers.
// Reset (rst_ni low, asynchronous) loads the default configuration,
// empties the pipeline and clears the running key.
module texture_rotate_add_hash
  import trah_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  trah_in_if.sink             in_if,
  trah_out_if.source          out_if,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t cfg;

  trah_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  trah_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_if.valid),
    .in_word_i   (in_if.data_word),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_key_o   (out_if.hash_key),
    .out_ok_o    (out_if.ok),
    .out_ready_i (out_if.ready)
  );

endmodule

// ===== tb/texture_rotate_add_hash_tb.sv =====
module texture_rotate_add_hash_tb;
  import trah_pkg::*;

  // Cycles with no beat on any port before the run is declared hung
  localparam int unsigned QuietLimit = 3000;

  // Indexes past the register list; a write there only restarts the texture
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [WordW-1:0] hash_key;
    logic             ok;
  } key_beat_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  trah_in_if  in_ch ();
  trah_out_if out_ch ();

  texture_rotate_add_hash i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // Shadow configuration and hash state
  logic [DimW-1:0]   cfg_width;
  logic [DimW-1:0]   cfg_height;
  logic [SizeW-1:0]  cfg_size;
  logic [PitchW-1:0] cfg_pitch;
  logic [BufW-1:0]   cfg_buf;
  logic [WordW-1:0]  acc_key;
  logic [OffW-1:0]   acc_off;
  logic [DimW-1:0]   acc_row;

  key_beat_t pending_keys[$];

  int err_count    = 0;
  int keys_seen    = 0;
  int words_sent   = 0;
  int quiet_cycles = 0;
  int src_gap_max  = 8;
  int sink_gap_max = 8;
  int sink_wait    = 0;
  int sink_hold    = 0;
  int hold_request = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Row bytes for a width and size code
  function automatic logic [OffW-1:0] row_bytes(input logic [DimW-1:0]  w,
                                                input logic [SizeW-1:0] s);
    logic [16:0] t;
    t = ({4'b0000, w} << s[1:0]) + 17'd1;
    return t[OffW:1];
  endfunction

  function automatic bit cfg_sane();
    logic [OffW-1:0] bpl;
    longint          pitch;
    longint          need;
    bpl = row_bytes(cfg_width, cfg_size);
    if (cfg_size > 3'd3 || cfg_width == '0 || cfg_height == '0) return 1'b0;
    if (bpl < WordBytes) return 1'b0;
    pitch = (cfg_pitch != '0) ? longint'(cfg_pitch) : longint'(bpl);
    if (pitch < longint'(bpl)) return 1'b0;
    need = (longint'(cfg_height) - 1) * pitch + longint'(bpl);
    return need <= longint'(cfg_buf);
  endfunction

  function automatic void hash_restart();
    logic [OffW-1:0] bpl;
    bpl = row_bytes(cfg_width, cfg_size);
    acc_key = '0;
    acc_off = (bpl >= WordBytes) ? bpl - WordBytes : '0;
    acc_row = (cfg_height != '0) ? cfg_height - 1'b1 : '0;
  endfunction

  function automatic void hash_defaults();
    cfg_width  = TexWidthRst;
    cfg_height = TexHeightRst;
    cfg_size   = SizeCodeRst;
    cfg_pitch  = RowPitchRst;
    cfg_buf    = BufBytesRst;
    hash_restart();
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0]  idx,
                                    input logic [CfgDataW-1:0] data);
    case (idx)
      REG_TEX_WIDTH:  cfg_width  = data[DimW-1:0];
      REG_TEX_HEIGHT: cfg_height = data[DimW-1:0];
      REG_SIZE_CODE:  cfg_size   = data[SizeW-1:0];
      REG_ROW_PITCH:  cfg_pitch  = data[PitchW-1:0];
      REG_BUF_BYTES:  cfg_buf    = data[BufW-1:0];
      default: ;
    endcase
    hash_restart();
  endfunction

  // Fold one word into the key; queue a key beat when the texture completes or the setup is bad
  function automatic void hash_step(input logic [WordW-1:0] word);
    logic [WordW-1:0] mixed;
    if (!cfg_sane()) begin
      hash_restart();
      pending_keys.push_back('{hash_key: '0, ok: 1'b0});
      return;
    end
    mixed   = word ^ WordW'(acc_off);
    acc_key = ((acc_key << RotAmt) | (acc_key >> (WordW - RotAmt))) + mixed;
    if (acc_off >= WordBytes) begin
      acc_off = acc_off - WordBytes;
      return;
    end
    acc_key = acc_key + (mixed ^ WordW'(acc_row));
    if (acc_row == '0) begin
      pending_keys.push_back('{hash_key: acc_key, ok: 1'b1});
      hash_restart();
    end else begin
      acc_row = acc_row - 1'b1;
      acc_off = row_bytes(cfg_width, cfg_size) - WordBytes;
    end
  endfunction

  // Words in one texture under the shadow configuration, 0 when it is bad
  function automatic int texture_words();
    if (!cfg_sane()) return 0;
    return int'(row_bytes(cfg_width, cfg_size) >> 2) * int'(cfg_height);
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) hash_step(in_ch.data_word);
  end

  // Check every accepted key beat against the oldest prediction
  always @(posedge clk_i) begin
    key_beat_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      keys_seen++;
      sink_wait = $urandom_range(0, sink_gap_max);
      if (pending_keys.size() == 0) begin
        $error("unexpected beat: hash_key %h ok %b", out_ch.hash_key, out_ch.ok);
        err_count++;
      end else begin
        want = pending_keys.pop_front();
        if (out_ch.hash_key !== want.hash_key) begin
          $error("hash_key: expected %h, actual %h", want.hash_key, out_ch.hash_key);
          err_count++;
        end
        if (out_ch.ok !== want.ok) begin
          $error("ok: expected %b, actual %b", want.ok, out_ch.ok);
          err_count++;
        end
      end
    end
  end

  // Drive ready: hold off for a requested stretch, else for the drawn wait
  always @(negedge clk_i) begin
    if (hold_request != 0) begin
      sink_hold    = hold_request;
      hold_request = 0;
    end
    if (sink_hold != 0) begin
      sink_hold--;
      out_ch.ready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we || (in_ch.valid && in_ch.ready) ||
        (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Offer one word after a random gap and hold it until accepted
  task automatic send_word(input logic [WordW-1:0] word);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk_i);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_word <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
  endtask

  task automatic send_random_words(input int count);
    repeat (count) send_word($urandom);
  endtask

  // Drop valid, wait for every predicted key, then let the block go quiet
  task automatic drain_results();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_keys.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0]  idx,
                           input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    apply_reg(idx, data);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Write one register while idle and let the checks settle
  task automatic poke_reg(input logic [CfgIdxW-1:0]  idx,
                          input logic [CfgDataW-1:0] data);
    drain_results();
    write_reg(idx, data);
    repeat (2) @(negedge clk_i);
  endtask

  // Write all five registers; with junk set, noise fills the unused high bits of the data
  task automatic program_texture(input logic [DimW-1:0]   w,
                                 input logic [DimW-1:0]   h,
                                 input logic [SizeW-1:0]  s,
                                 input logic [PitchW-1:0] p,
                                 input logic [BufW-1:0]   b,
                                 input bit                junk);
    logic [CfgDataW-1:0] noise;
    noise = junk ? CfgDataW'($urandom) : '0;
    drain_results();
    write_reg(REG_TEX_WIDTH,  {noise[CfgDataW-1:DimW], w});
    write_reg(REG_TEX_HEIGHT, {noise[CfgDataW-1:DimW], h});
    write_reg(REG_SIZE_CODE,  {noise[CfgDataW-1:SizeW], s});
    write_reg(REG_ROW_PITCH,  {noise[CfgDataW-1:PitchW], p});
    write_reg(REG_BUF_BYTES,  b);
    repeat (2) @(negedge clk_i);
  endtask

  // Program, then send count whole textures, or count words if the setup is bad
  task automatic hash_textures(input logic [DimW-1:0]   w,
                               input logic [DimW-1:0]   h,
                               input logic [SizeW-1:0]  s,
                               input logic [PitchW-1:0] p,
                               input logic [BufW-1:0]   b,
                               input int                count);
    int n;
    program_texture(w, h, s, p, b, 1'b0);
    n = texture_words();
    send_random_words((n != 0) ? n * count : count);
    drain_results();
  endtask

  // Reset configuration: four-byte rows, one row, so every word is a texture
  task automatic test_default_config();
    send_word(32'h0000_0000);
    send_word(32'hFFFF_FFFF);
    send_word(32'h8000_0000);
    send_word(32'h0000_0001);
    drain_results();
  endtask

  // Thirteen-byte rows: offsets step down past a remainder; pitch and buffer exact
  task automatic test_row_walk();
    hash_textures(13'd13, 13'd2, 3'd1, 16'd13, 24'd26, 1);
  endtask

  task automatic test_bad_configs();
    hash_textures(13'd8, 13'd1, 3'd4, 16'd0, '1, 1);      // size code too high
    hash_textures(13'd8, 13'd1, 3'd7, 16'd0, '1, 1);
    hash_textures(13'd0, 13'd1, 3'd0, 16'd0, '1, 1);      // zero width
    hash_textures(13'd8, 13'd0, 3'd0, 16'd0, '1, 1);      // zero height
    hash_textures(13'd3, 13'd1, 3'd1, 16'd0, '1, 1);      // row under four bytes
    hash_textures(13'd16, 13'd2, 3'd0, 16'd7, '1, 1);     // pitch under the row
    hash_textures(13'd8, 13'd3, 3'd0, 16'd0, 24'd11, 2);  // span one past the buffer
    hash_textures(13'd8, 13'd1, 3'd0, 16'd0, 24'd0, 1);   // empty buffer
  endtask

  // Any write restarts a texture, a write past the register list too
  task automatic test_restart_on_write();
    program_texture(13'd16, 13'd1, 3'd0, 16'd0, '1, 1'b0);
    send_word($urandom);
    poke_reg(CfgIdxW'($urandom_range(RegSpareLo, RegSpareHi)), CfgDataW'($urandom));
    send_random_words(2);
    send_word($urandom);
    poke_reg(REG_ROW_PITCH, '0);
    send_random_words(2);
    drain_results();
  endtask

  // Wide rows, many rows and the largest pitch; the extreme sizes one byte past the buffer
  task automatic test_large_textures();
    src_gap_max  = 1;
    sink_gap_max = 1;
    hash_textures(13'd64, 13'd1, 3'd3, 16'd0, '1, 1);
    hash_textures(13'd8191, 13'd1, 3'd3, 16'd0, 24'd32763, 1);
    hash_textures(13'd8, 13'd48, 3'd0, 16'd0, '1, 1);
    hash_textures(13'd8, 13'd8191, 3'd0, 16'd4, 24'd32763, 1);
    hash_textures(13'd8, 13'd2, 3'd0, 16'hFFFF, 24'd65539, 2);
    hash_textures(13'd8, 13'd256, 3'd0, 16'hFFFF, 24'd16711428, 2);
    hash_textures(13'd4096, 13'd4096, 3'd3, 16'd0, '1, 2);
    src_gap_max  = 8;
    sink_gap_max = 8;
  endtask

  // Hold off the key sink while words keep coming, so the input stalls
  task automatic test_output_backpressure();
    program_texture(13'd8, 13'd1, 3'd0, 16'd0, '1, 1'b0);
    src_gap_max  = 0;
    hold_request = 300;
    send_random_words(32);
    drain_results();
    src_gap_max = 8;
  endtask

  // Pause the sender mid-texture until every key is out, then resume
  task automatic test_sender_pause();
    program_texture(13'd8, 13'd2, 3'd0, 16'd0, '1, 1'b0);
    send_random_words(5);
    drain_results();
    send_random_words(3);
    drain_results();
  endtask

  // Mostly well-formed small textures, with bad setups and abandoned textures mixed in
  task automatic test_random_textures();
    int              first_word;
    int              first_key;
    int              n;
    logic [DimW-1:0]   w;
    logic [DimW-1:0]   h;
    logic [SizeW-1:0]  s;
    logic [PitchW-1:0] p;
    logic [BufW-1:0]   b;
    logic [OffW-1:0]   bpl;
    longint            need;
    first_word = words_sent;
    first_key  = keys_seen;
    while (words_sent - first_word < 300 || keys_seen - first_key < 24) begin
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 8;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
      if ($urandom_range(0, 3) != 0) begin
        do begin
          w   = DimW'($urandom_range(1, 16));
          s   = SizeW'($urandom_range(0, 3));
          bpl = row_bytes(w, s);
        end while (bpl < WordBytes);
        h = DimW'($urandom_range(1, 4));
        p = ($urandom_range(0, 1) != 0) ? '0 : PitchW'(bpl + $urandom_range(0, 100));
        need = (longint'(h) - 1) * ((p != '0) ? longint'(p) : longint'(bpl)) +
               longint'(bpl);
        case ($urandom_range(0, 3))
          0:       b = BufW'(need);
          1:       b = BufW'(need + $urandom_range(1, 1000));
          default: b = '1;
        endcase
      end else begin
        w = DimW'($urandom_range(0, 20));
        s = SizeW'($urandom_range(0, 7));
        h = DimW'($urandom_range(0, 4));
        p = PitchW'($urandom_range(0, 40));
        b = BufW'($urandom_range(0, 200));
      end
      program_texture(w, h, s, p, b, $urandom_range(0, 3) == 0);
      n = texture_words();
      if (n == 0) begin
        send_random_words($urandom_range(1, 6));
      end else begin
        send_random_words(n * $urandom_range(1, 3));
        // Abandon a texture partway with a restarting write, then finish one
        if (n > 1 && $urandom_range(0, 3) == 0) begin
          send_random_words($urandom_range(1, n - 1));
          if ($urandom_range(0, 1) != 0)
            poke_reg(CfgIdxW'($urandom_range(RegSpareLo, RegSpareHi)),
                     CfgDataW'($urandom));
          else
            poke_reg(REG_BUF_BYTES, cfg_buf);
          send_random_words(n);
        end
      end
    end
    drain_results();
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_word = '0;
    out_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    hash_defaults();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    test_default_config();
    test_row_walk();
    test_bad_configs();
    test_restart_on_write();
    test_large_textures();
    test_output_backpressure();
    test_sender_pause();
    test_random_textures();

    drain_results();
    repeat (5) @(posedge clk_i);
    if (pending_keys.size() != 0) begin
      $error("%0d predicted key beats never arrived", pending_keys.size());
      err_count++;
    end
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
